// File: src/kpec_pkg.sv
// Shared types and constants for the key press event classifier.
package kpec_pkg;

   localparam int unsigned PIN_W   = 6;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned IDX_W   = 3;

   localparam logic [COUNT_W-1:0] SHORT_HOLD_RST    = 8'd5;
   localparam logic [COUNT_W-1:0] LONG_HOLD_RST     = 8'd248;
   localparam logic [COUNT_W-1:0] HOLD_CAP_RST      = 8'd250;
   localparam logic [COUNT_W-1:0] RELEASE_MAX_RST   = 8'd150;
   localparam logic [COUNT_W-1:0] REPEAT_AFTER_RST  = 8'd60;
   localparam logic [COUNT_W-1:0] REPEAT_RELOAD_RST = 8'd45;

   typedef enum logic [1:0] {
      EV_SHORT   = 2'd0,
      EV_LONG    = 2'd1,
      EV_REPEAT  = 2'd2,
      EV_RELEASE = 2'd3
   } event_type;

   typedef enum logic [IDX_W-1:0] {
      REG_SHORT_HOLD    = 3'd0,
      REG_LONG_HOLD     = 3'd1,
      REG_HOLD_CAP      = 3'd2,
      REG_RELEASE_MAX   = 3'd3,
      REG_REPEAT_AFTER  = 3'd4,
      REG_REPEAT_RELOAD = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] short_hold;
      logic [COUNT_W-1:0] long_hold;
      logic [COUNT_W-1:0] hold_cap;
      logic [COUNT_W-1:0] release_max;
      logic [COUNT_W-1:0] repeat_after;
      logic [COUNT_W-1:0] repeat_reload;
   } cfg_type;

   typedef struct packed {
      logic             have;
      event_type        ev;
      logic [PIN_W-1:0] code;
   } result_type;

endpackage

// File: src/kpec_csr.sv
// Configuration register file for the key press event classifier.
module kpec_csr
   import kpec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_index,
   input  logic [COUNT_W-1:0] wr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(wr_index))
            REG_SHORT_HOLD:    cfg_in.short_hold    = wr_data;
            REG_LONG_HOLD:     cfg_in.long_hold     = wr_data;
            REG_HOLD_CAP:      cfg_in.hold_cap      = wr_data;
            REG_RELEASE_MAX:   cfg_in.release_max   = wr_data;
            REG_REPEAT_AFTER:  cfg_in.repeat_after  = wr_data;
            REG_REPEAT_RELOAD: cfg_in.repeat_reload = wr_data;
            default:           cfg_in = cfg_ff;  // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_hold    <= SHORT_HOLD_RST;
         cfg_ff.long_hold     <= LONG_HOLD_RST;
         cfg_ff.hold_cap      <= HOLD_CAP_RST;
         cfg_ff.release_max   <= RELEASE_MAX_RST;
         cfg_ff.repeat_after  <= REPEAT_AFTER_RST;
         cfg_ff.repeat_reload <= REPEAT_RELOAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/kpec_update.sv
// Held-code and counter state with the per-tick event decision.
module kpec_update
   import kpec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [PIN_W-1:0] key_pins,
   input  cfg_type          cfg,
   output result_type       res
);

   logic [PIN_W-1:0]   held_code_ff, held_code_in;
   logic [COUNT_W-1:0] hold_count_ff, hold_count_in;
   logic [COUNT_W-1:0] repeat_count_ff, repeat_count_in;

   logic [PIN_W-1:0]   code;
   logic [COUNT_W-1:0] hold_inc;
   logic [COUNT_W-1:0] repeat_inc;
   logic               repeat_hit;

   assign code       = ~key_pins;
   assign hold_inc   = (hold_count_ff == '1) ? hold_count_ff : hold_count_ff + 1'b1;
   assign repeat_inc = (repeat_count_ff == '1) ? repeat_count_ff : repeat_count_ff + 1'b1;
   assign repeat_hit = repeat_inc > cfg.repeat_after;

   always_comb begin
      held_code_in    = held_code_ff;
      hold_count_in   = hold_count_ff;
      repeat_count_in = repeat_count_ff;
      res.have        = 1'b0;
      res.ev          = EV_SHORT;
      res.code        = code;
      if (code != held_code_ff) begin
         // key change: counters carry over, release only inside the window
         held_code_in = code;
         if (code == '0 && hold_count_ff > cfg.short_hold
             && hold_count_ff < cfg.release_max) begin
            res.have = 1'b1;
            res.ev   = EV_RELEASE;
         end
      end else if (held_code_ff == '0) begin
         hold_count_in   = '0;
         repeat_count_in = '0;
      end else begin
         hold_count_in   = hold_inc;
         repeat_count_in = repeat_hit ? cfg.repeat_reload : repeat_inc;
         if (hold_inc == cfg.short_hold) begin
            res.have = 1'b1;
            res.ev   = EV_SHORT;
         end else if (hold_inc == cfg.long_hold) begin
            res.have = 1'b1;
            res.ev   = EV_LONG;
         end else begin
            // clamp only on ticks without a short or long event
            if (hold_inc > cfg.hold_cap) begin
               hold_count_in = cfg.hold_cap;
            end
            if (repeat_hit) begin
               res.have = 1'b1;
               res.ev   = EV_REPEAT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff    <= '0;
         hold_count_ff   <= '0;
         repeat_count_ff <= '0;
      end else if (step) begin
         held_code_ff    <= held_code_in;
         hold_count_ff   <= hold_count_in;
         repeat_count_ff <= repeat_count_in;
      end
   end

endmodule

// File: src/key_press_event_classifier.sv
// Top level of the key press event classifier: input and result registers.
//
// Usage: each transfer on the req_ channel is one scan tick carrying the six
// active-low key pins in req_tdata[5:0]. A tick yields zero or one result on
// the rsp_ channel: rsp_tuser holds the event (short, long, repeat, release)
// and rsp_tdata[5:0] the key code held after that tick.
// The csr_ channel writes the six 8-bit thresholds by index; csr_ready is
// always high. Write them only while no tick is in flight.
// Path: a tick is captured in the input register, evaluated combinationally
// against the held code and the two counters, and its event lands in the
// result register, which drives rsp_tvalid; while the result register is
// stalled, the tick waits in the input register.
// Throughput: one tick per cycle unless the result register stalls; the
// state update between both registers is compares and saturating increments.
// Reset clears the held code, both counters, the pipeline and loads the
// default thresholds. When the receiver stalls, the result register holds
// its event, the input register fills and then req_tready drops.
module key_press_event_classifier
   import kpec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [5:0] key_pins, [7:6] zero
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [5:0] held key code, [7:6] zero
   output logic [1:0]         rsp_tuser,   // [1:0] event_res
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type res;

   logic             in_vld_ff, in_vld_in;
   logic [PIN_W-1:0] in_pins_ff;
   logic             out_vld_ff, out_vld_in;
   event_type        out_ev_ff;
   logic [PIN_W-1:0] out_code_ff;
   logic             out_space;
   logic             fire;
   logic             req_xfer;

   assign csr_ready = 1'b1;

   kpec_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   kpec_update u_update (
      .clock    (clock),
      .reset    (reset),
      .step     (fire),
      .key_pins (in_pins_ff),
      .cfg      (cfg),
      .res      (res)
   );

   assign out_space  = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_space;
   assign req_tready = !in_vld_ff || fire;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_vld_in  = req_xfer || (in_vld_ff && !fire);
   assign out_vld_in = fire ? res.have : (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_pins_ff <= req_tdata[PIN_W-1:0];
      end
      if (fire && res.have) begin
         out_ev_ff   <= res.ev;
         out_code_ff <= res.code;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_code_ff};
   assign rsp_tuser  = out_ev_ff;

`ifndef SYNTH
   a_reset_empty : assert property (@(posedge clock) reset |=> !out_vld_ff && !in_vld_ff)
      else $error("pipeline not empty after reset");
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(in_pins_ff))
      else $error("stalled tick lost from input register");
   a_result_load : assert property (@(posedge clock) disable iff (reset)
      fire && res.have |=> out_vld_ff)
      else $error("event not loaded into result register");
   a_release_empty : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ev_ff == EV_RELEASE |-> out_code_ff == '0)
      else $error("release event with a key still held");
`endif

endmodule

// File: dv/tb_key_press_event_classifier.sv
// Self-checking testbench for the key press event classifier: stream stimulus and scoreboard.
module tb_key_press_event_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import kpec_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [IDX_W-1:0] REG_SPARE_LO  = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_HI  = 3'd7;
   localparam logic [PIN_W-1:0] PINS_RELEASED = 6'h3F;

   typedef struct packed {
      event_type        ev;
      logic [PIN_W-1:0] code;
   } key_event_type;

   class key_event_scoreboard;
      cfg_type            cfg;
      logic [PIN_W-1:0]   held_code;
      logic [COUNT_W-1:0] hold_count;
      logic [COUNT_W-1:0] repeat_count;
      key_event_type      pending_events[$];
      int                 fail_count;

      function new();
         cfg = '{short_hold: SHORT_HOLD_RST, long_hold: LONG_HOLD_RST,
                 hold_cap: HOLD_CAP_RST, release_max: RELEASE_MAX_RST,
                 repeat_after: REPEAT_AFTER_RST, repeat_reload: REPEAT_RELOAD_RST};
         held_code    = '0;
         hold_count   = '0;
         repeat_count = '0;
         fail_count   = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
         case (idx)
            REG_SHORT_HOLD:    cfg.short_hold    = val;
            REG_LONG_HOLD:     cfg.long_hold     = val;
            REG_HOLD_CAP:      cfg.hold_cap      = val;
            REG_RELEASE_MAX:   cfg.release_max   = val;
            REG_REPEAT_AFTER:  cfg.repeat_after  = val;
            REG_REPEAT_RELOAD: cfg.repeat_reload = val;
            default: ;
         endcase
      endfunction

      function logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function void note_tick(logic [PIN_W-1:0] pins);
         logic [PIN_W-1:0] code;
         logic             fired;
         event_type        ev;
         code  = ~pins;
         fired = 1'b0;
         ev    = EV_SHORT;
         if (code != held_code) begin
            if (code == '0 && hold_count > cfg.short_hold
                && hold_count < cfg.release_max) begin
               fired = 1'b1;
               ev    = EV_RELEASE;
            end
            held_code = code;
         end else if (held_code == '0) begin
            hold_count   = '0;
            repeat_count = '0;
         end else begin
            hold_count   = sat_inc(hold_count);
            repeat_count = sat_inc(repeat_count);
            if (repeat_count > cfg.repeat_after) begin
               repeat_count = cfg.repeat_reload;
               fired        = 1'b1;
               ev           = EV_REPEAT;
            end
            // short and long win over a repeat on the same tick
            if (hold_count == cfg.short_hold) begin
               fired = 1'b1;
               ev    = EV_SHORT;
            end else if (hold_count == cfg.long_hold) begin
               fired = 1'b1;
               ev    = EV_LONG;
            end else if (hold_count > cfg.hold_cap) begin
               hold_count = cfg.hold_cap;
            end
         end
         if (fired)
            pending_events.push_back('{ev: ev, code: held_code});
      endfunction

      function void check_event(logic [1:0] ev_bits, logic [PIN_W-1:0] code);
         key_event_type want;
         if (pending_events.size() == 0) begin
            $error("unexpected event: event_res %0d held code 0x%0h", ev_bits, code);
            fail_count++;
            return;
         end
         want = pending_events.pop_front();
         if (ev_bits !== want.ev) begin
            $error("event_res mismatch: expected %0d, actual %0d", want.ev, ev_bits);
            fail_count++;
         end
         if (code !== want.code) begin
            $error("held_key mismatch: expected 0x%0h, actual 0x%0h", want.code, code);
            fail_count++;
         end
      endfunction

      function bit busy();
         return pending_events.size() != 0;
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index  = '0;
   logic [COUNT_W-1:0] csr_wdata  = '0;

   key_event_scoreboard board = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_left     = 0;
   int quiet_cycles   = 0;

   key_press_event_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_event(rsp_tuser, rsp_tdata[PIN_W-1:0]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Called and returns just after a falling edge.
   task automatic send_tick(logic [PIN_W-1:0] pins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, pins};
      do @(posedge clock); while (!req_tready);
      board.note_tick(pins);
      items_left--;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(int sh, int lh, int cap, int rel, int after, int reload);
      write_reg(REG_SHORT_HOLD, COUNT_W'(sh));
      write_reg(REG_LONG_HOLD, COUNT_W'(lh));
      write_reg(REG_HOLD_CAP, COUNT_W'(cap));
      write_reg(REG_RELEASE_MAX, COUNT_W'(rel));
      write_reg(REG_REPEAT_AFTER, COUNT_W'(after));
      write_reg(REG_REPEAT_RELOAD, COUNT_W'(reload));
      // spare indexes must leave every threshold alone
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                COUNT_W'($urandom_range(255)));
   endtask

   // Drop valid and wait until no tick is in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.busy()) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic hold_key(logic [PIN_W-1:0] code, int ticks);
      repeat (ticks) send_tick(~code);
   endtask

   task automatic press_sequence();
      logic [PIN_W-1:0] code;
      int hold_len;
      int lim;
      code = PIN_W'($urandom_range(1, 63));
      lim  = int'((board.cfg.long_hold > board.cfg.hold_cap) ? board.cfg.long_hold
                                                             : board.cfg.hold_cap);
      case ($urandom_range(3))
         0:       hold_len = $urandom_range(0, board.cfg.short_hold + 2);
         1:       hold_len = $urandom_range(board.cfg.short_hold, board.cfg.release_max + 1);
         2:       hold_len = $urandom_range(board.cfg.long_hold, board.cfg.long_hold + 2);
         default: hold_len = $urandom_range(0, lim + 3);
      endcase
      send_tick(~code);
      for (int i = 0; i < hold_len && items_left > 0; i++) begin
         // switch keys now and then without a release in between
         if ($urandom_range(99) < 4)
            code = PIN_W'($urandom_range(1, 63));
         send_tick(~code);
      end
      repeat ($urandom_range(1, 3))
         if (items_left > 0)
            send_tick(PINS_RELEASED);
   endtask

   task automatic run_phase(int phase, int n_items);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
         default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (phase)
         1: write_all(1, 1, 1, 1, 0, 0);
         2: write_all(255, 255, 255, 255, 255, 255);
         3: write_all(SHORT_HOLD_RST, LONG_HOLD_RST, HOLD_CAP_RST, RELEASE_MAX_RST,
                      REPEAT_AFTER_RST, REPEAT_RELOAD_RST);
         5: write_all($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
         default: write_all($urandom_range(1, 12), $urandom_range(1, 40), $urandom_range(1, 45),
                            $urandom_range(1, 40), $urandom_range(0, 15), $urandom_range(0, 20));
      endcase
      items_left = n_items;
      while (items_left > 0) begin
         if ($urandom_range(99) < 15)
            send_tick(PIN_W'($urandom_range(63)));
         else
            press_sequence();
      end
      settle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: short press, release inside the window, all keys, no release
      items_left = 1000;
      hold_key(6'h01, 7);
      hold_key(6'h00, 2);
      hold_key(6'h3F, 1);
      hold_key(6'h00, 1);
      settle();

      // tight thresholds: repeat coinciding with short and long, clamp, key change, release
      write_all(2, 6, 8, 20, 1, 0);
      hold_key(6'h2A, 12);
      hold_key(6'h15, 2);
      hold_key(6'h00, 2);
      settle();

      for (int p = 0; p < 8; p++)
         run_phase(p, (p == 2 || p == 3) ? 400 : 130);

      while (board.busy()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
